// ===== hdl/c_like_source_lexer_assert.svh =====
// Assertion macros shared by the lexer RTL.
// Uses the clk and rst_n names of the module that includes this file.
`ifndef C_LIKE_SOURCE_LEXER_ASSERT_SVH
`define C_LIKE_SOURCE_LEXER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CLSL_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CLSL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CLSL_ASSERT(label, cond, msg)
`define CLSL_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

// ===== hdl/clsl_pkg.sv =====
// Shared types, token codes and word tables of the source lexer.
// No dependencies.
package clsl_pkg;

    localparam int OFFSET_BITS   = 32;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // token kinds
    localparam logic [5:0] KIND_IDENT   = 6'd0;
    localparam logic [5:0] KIND_LPAREN  = 6'd1;
    localparam logic [5:0] KIND_RPAREN  = 6'd2;
    localparam logic [5:0] KIND_LBRACK  = 6'd3;
    localparam logic [5:0] KIND_RBRACK  = 6'd4;
    localparam logic [5:0] KIND_LBRACE  = 6'd5;
    localparam logic [5:0] KIND_RBRACE  = 6'd6;
    localparam logic [5:0] KIND_COLON   = 6'd7;
    localparam logic [5:0] KIND_SEMI    = 6'd8;
    localparam logic [5:0] KIND_STAR    = 6'd9;
    localparam logic [5:0] KIND_EQEQ    = 6'd10;
    localparam logic [5:0] KIND_ASSIGN  = 6'd11;
    localparam logic [5:0] KIND_STRING  = 6'd12;
    localparam logic [5:0] KIND_NUMBER  = 6'd13;
    localparam logic [5:0] KIND_UNKNOWN = 6'd34;
    localparam logic [5:0] KIND_END     = 6'd35;

    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_EQ         = 4'd2,
        MODE_IDENT      = 4'd3,
        MODE_NUMBER     = 4'd4,
        MODE_STRING     = 4'd5,
        MODE_STRING_ESC = 4'd6,
        MODE_LINE       = 4'd7,
        MODE_BLOCK      = 4'd8,
        MODE_BLOCK_STAR = 4'd9,
        MODE_MACRO      = 4'd10,
        MODE_MACRO_CONT = 4'd11
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
    } token_t;

    typedef struct packed {
        token_t tok;
        logic   last;
    } entry_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } step_t;

    typedef struct packed {
        logic                     room;
        logic [FIFO_CNT_BITS-1:0] count;
    } fifo_status_t;

    // word text packed with its first byte in the low bits
    typedef struct packed {
        logic [47:0] txt;
        logic [2:0]  len;
        logic [5:0]  kind;
    } word_entry_t;

    localparam word_entry_t KEYWORDS [9] = '{
        '{48'("fi"),     3'd2, 6'd14},
        '{48'("esle"),   3'd4, 6'd15},
        '{48'("rof"),    3'd3, 6'd16},
        '{48'("elihw"),  3'd5, 6'd17},
        '{48'("od"),     3'd2, 6'd18},
        '{48'("otog"),   3'd4, 6'd19},
        '{48'("tcurts"), 3'd6, 6'd20},
        '{48'("ssalc"),  3'd5, 6'd21},
        '{48'("nruter"), 3'd6, 6'd22}
    };

    localparam word_entry_t TYPES [11] = '{
        '{48'("diov"), 3'd4, 6'd23},
        '{48'("8i"),   3'd2, 6'd24},
        '{48'("61i"),  3'd3, 6'd25},
        '{48'("23i"),  3'd3, 6'd26},
        '{48'("46i"),  3'd3, 6'd27},
        '{48'("8u"),   3'd2, 6'd28},
        '{48'("61u"),  3'd3, 6'd29},
        '{48'("23u"),  3'd3, 6'd30},
        '{48'("46u"),  3'd3, 6'd31},
        '{48'("23f"),  3'd3, 6'd32},
        '{48'("46f"),  3'd3, 6'd33}
    };

    // Exact match of the whole identifier; keywords only for all-letter words.
    function automatic logic [5:0] word_kind(input logic [47:0] prefix,
                                             input logic [2:0]  len3,
                                             input logic        len_ok,
                                             input logic        letters);
        logic [5:0] kind;
        kind = KIND_IDENT;
        for (int i = 10; i >= 0; i--) begin
            if (len_ok && len3 == TYPES[i].len && prefix == TYPES[i].txt)
                kind = TYPES[i].kind;
        end
        for (int i = 8; i >= 0; i--) begin
            if (letters && len_ok && len3 == KEYWORDS[i].len && prefix == KEYWORDS[i].txt)
                kind = KEYWORDS[i].kind;
        end
        return kind;
    endfunction

endpackage

// ===== hdl/clsl_core.sv =====
// Scanner state and per-byte token decode of the source lexer.
// Depends on clsl_pkg.
module clsl_core
    import clsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] char_byte,
    output step_t      step
);

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [47:0]            prefix_reg, prefix_next;
    logic                   letters_reg, letters_next;

    logic [OFFSET_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                   len_ok;
    logic                   c_alpha, c_digit;

    // idle dispatch of the current byte
    mode_t                  d_mode;
    logic                   d_emit;
    logic [5:0]             d_kind;
    logic                   d_begin_en;
    logic [OFFSET_BITS-1:0] d_begin_val;
    logic                   d_word;

    // decode of the pending token
    logic                   disp_en;
    logic                   pend_emit;
    logic [5:0]             pend_kind;
    logic [OFFSET_BITS-1:0] pend_len;
    token_t                 pend_tok, disp_tok;

    assign len     = pos_reg - begin_reg;
    assign pos_inc = (pos_reg == OFFSET_MAX) ? OFFSET_MAX : pos_reg + 1'b1;
    assign len_ok  = (len <= OFFSET_BITS'(6));
    assign c_alpha = (char_byte >= "a" && char_byte <= "z") ||
                     (char_byte >= "A" && char_byte <= "Z");
    assign c_digit = (char_byte >= "0" && char_byte <= "9");

    always_comb
    begin
        d_mode      = MODE_IDLE;
        d_emit      = 1'b0;
        d_kind      = KIND_UNKNOWN;
        d_begin_en  = 1'b0;
        d_begin_val = pos_reg;
        d_word      = 1'b0;
        case (char_byte)
            8'h00: begin d_emit = 1'b1; d_kind = KIND_END; end
            " ", 8'h09, 8'h0d, 8'h0a: ;
            "(": begin d_emit = 1'b1; d_kind = KIND_LPAREN; end
            ")": begin d_emit = 1'b1; d_kind = KIND_RPAREN; end
            "[": begin d_emit = 1'b1; d_kind = KIND_LBRACK; end
            "]": begin d_emit = 1'b1; d_kind = KIND_RBRACK; end
            "{": begin d_emit = 1'b1; d_kind = KIND_LBRACE; end
            "}": begin d_emit = 1'b1; d_kind = KIND_RBRACE; end
            ":": begin d_emit = 1'b1; d_kind = KIND_COLON; end
            ";": begin d_emit = 1'b1; d_kind = KIND_SEMI; end
            "*": begin d_emit = 1'b1; d_kind = KIND_STAR; end
            "/": begin d_mode = MODE_SLASH; d_begin_en = 1'b1; end
            "=": begin d_mode = MODE_EQ; d_begin_en = 1'b1; end
            "#": d_mode = MODE_MACRO;
            8'h22:
            begin
                d_mode      = MODE_STRING;
                d_begin_en  = 1'b1;
                d_begin_val = pos_inc;
            end
            default:
            begin
                if (c_digit) begin
                    d_mode     = MODE_NUMBER;
                    d_begin_en = 1'b1;
                end else if (c_alpha) begin
                    d_mode     = MODE_IDENT;
                    d_begin_en = 1'b1;
                    d_word     = 1'b1;
                end else begin
                    d_emit = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        disp_en   = 1'b0;
        pend_emit = 1'b0;
        pend_kind = KIND_UNKNOWN;
        pend_len  = len;
        case (mode_reg)
            MODE_IDENT:
            begin
                if (!(c_alpha || c_digit || char_byte == "_")) begin
                    pend_emit = 1'b1;
                    pend_kind = word_kind(prefix_reg, len[2:0], len_ok, letters_reg);
                    disp_en   = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (!c_digit) begin
                    pend_emit = 1'b1;
                    pend_kind = KIND_NUMBER;
                    disp_en   = 1'b1;
                end
            end
            MODE_EQ:
            begin
                pend_emit = 1'b1;
                if (char_byte == "=") begin
                    pend_kind = KIND_EQEQ;
                    pend_len  = OFFSET_BITS'(2);
                end else begin
                    pend_kind = KIND_ASSIGN;
                    pend_len  = OFFSET_BITS'(1);
                    disp_en   = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (char_byte != "/" && char_byte != "*") begin
                    pend_emit = 1'b1;
                    pend_len  = OFFSET_BITS'(1);
                    disp_en   = 1'b1;
                end
            end
            MODE_STRING, MODE_STRING_ESC:
            begin
                pend_kind = KIND_STRING;
                if (char_byte == 8'h00) begin
                    pend_emit = 1'b1;
                    disp_en   = 1'b1;
                end else if (mode_reg == MODE_STRING && char_byte == 8'h22) begin
                    pend_emit = 1'b1;
                end
            end
            MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR, MODE_MACRO, MODE_MACRO_CONT:
            begin
                disp_en = (char_byte == 8'h00);
            end
            default: disp_en = 1'b1;
        endcase
    end

    // next scanner mode
    always_comb
    begin
        mode_next = mode_reg;
        if (disp_en) begin
            mode_next = d_mode;
        end else begin
            case (mode_reg)
                MODE_IDENT, MODE_NUMBER: mode_next = mode_reg;
                MODE_EQ: mode_next = MODE_IDLE;
                MODE_SLASH: mode_next = (char_byte == "/") ? MODE_LINE : MODE_BLOCK;
                MODE_STRING:
                begin
                    if (char_byte == 8'h22)
                        mode_next = MODE_IDLE;
                    else if (char_byte == 8'h5c)
                        mode_next = MODE_STRING_ESC;
                end
                MODE_STRING_ESC: mode_next = MODE_STRING;
                MODE_LINE: if (char_byte == 8'h0a) mode_next = MODE_IDLE;
                MODE_BLOCK, MODE_BLOCK_STAR:
                begin
                    if (char_byte == "*")
                        mode_next = MODE_BLOCK_STAR;
                    else if (mode_reg == MODE_BLOCK_STAR && char_byte == "/")
                        mode_next = MODE_IDLE;
                    else
                        mode_next = MODE_BLOCK;
                end
                MODE_MACRO:
                begin
                    if (char_byte == 8'h5c)
                        mode_next = MODE_MACRO_CONT;
                    else if (char_byte == 8'h0a)
                        mode_next = MODE_IDLE;
                end
                MODE_MACRO_CONT: if (char_byte == 8'h0a) mode_next = MODE_MACRO;
                default: mode_next = MODE_IDLE;
            endcase
        end
    end

    // token outputs and datapath updates
    always_comb
    begin
        pend_tok.kind   = pend_kind;
        pend_tok.start  = 32'(begin_reg);
        pend_tok.length = 32'(pend_len);
        disp_tok.kind   = d_kind;
        disp_tok.start  = 32'(pos_reg);
        disp_tok.length = 32'd1;

        step.count = {1'b0, pend_emit} + {1'b0, disp_en && d_emit};
        step.tok0  = pend_emit ? pend_tok : disp_tok;
        step.tok1  = disp_tok;

        pos_next     = pos_inc;
        begin_next   = (disp_en && d_begin_en) ? d_begin_val : begin_reg;
        prefix_next  = prefix_reg;
        letters_next = letters_reg;
        if (disp_en && d_word) begin
            prefix_next  = 48'(char_byte);
            letters_next = 1'b1;
        end else if (mode_reg == MODE_IDENT && !disp_en) begin
            // merge into the slot; once offsets stick, bytes pile into one slot
            if (len < OFFSET_BITS'(6))
                prefix_next[8*len[2:0] +: 8] = prefix_reg[8*len[2:0] +: 8] | char_byte;
            if (!c_alpha)
                letters_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_IDLE;
            pos_reg     <= '0;
            begin_reg   <= '0;
            prefix_reg  <= '0;
            letters_reg <= 1'b1;
        end else if (advance) begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            begin_reg   <= begin_next;
            prefix_reg  <= prefix_next;
            letters_reg <= letters_next;
        end
    end

endmodule

// ===== hdl/clsl_fifo.sv =====
// Result queue of the source lexer: takes up to two tokens a cycle, gives one.
// Depends on clsl_pkg.
module clsl_fifo
    import clsl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   push_count,
    input  token_t       push_tok0,
    input  token_t       push_tok1,
    input  logic         pop,
    output entry_t       head,
    output fifo_status_t status
);

    entry_t                   mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push_count);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
    assign count_next  = count_reg + FIFO_CNT_BITS'(push_count) - FIFO_CNT_BITS'(pop);

    assign head         = mem[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.room  = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem[wr_ptr_reg] <= '{tok: push_tok0, last: (push_count == 2'd1)};
        if (push_count == 2'd2)
            mem[wr_ptr_inc] <= '{tok: push_tok1, last: 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/c_like_source_lexer.sv =====
// Streaming lexer for a small C-like language: top level.
// Depends on clsl_pkg, clsl_core, clsl_fifo and c_like_source_lexer_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / char_byte) carries one source byte per
//   item; byte 0 ends the stream and yields an end token. Output channel
//   (out_valid / out_stall) carries one token per item: token_kind,
//   token_start, token_length and last_of_run, which marks the final token
//   caused by one byte. A byte may cause zero, one or two tokens.
//   An accepted byte is held in the input register, scanned from there, and
//   its tokens are written into the token queue that feeds the output.
//   Throughput: one byte per cycle while the token queue has room, set by the
//   scanner update; a byte that causes two tokens drains them one at a time.
//   The input register and the four-entry token queue decouple the sides:
//   bytes keep flowing while queued tokens wait on out_stall. The input
//   stalls only when the queue cannot take two more tokens.
//   Reset (rst_n low, asynchronous) empties the queue, drops any held byte,
//   returns the scanner to idle between tokens and zeroes the byte offset.
//   Offsets saturate at the top of the offset range.
module c_like_source_lexer
    import clsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [31:0] token_start,
    output logic [31:0] token_length,
    output logic        last_of_run
);

`include "c_like_source_lexer_assert.svh"

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   byte_reg;
    logic         in_accept;
    logic         advance;
    logic         pop;
    logic [1:0]   push_count;
    step_t        step;
    entry_t       head;
    fifo_status_t status;

    // Scan the held byte whenever the queue has room for its worst case.
    assign advance    = in_valid_reg && status.room;
    assign in_stall   = in_valid_reg && !status.room;
    assign in_accept  = in_valid && !in_stall;
    assign push_count = advance ? step.count : 2'd0;
    assign pop        = out_valid && !out_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // hold the byte payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
            byte_reg <= char_byte;
    end

    clsl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .char_byte (byte_reg),
        .step      (step)
    );

    clsl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_tok0  (step.tok0),
        .push_tok1  (step.tok1),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    assign out_valid    = (status.count != '0);
    assign token_kind   = head.tok.kind;
    assign token_start  = head.tok.start;
    assign token_length = head.tok.length;
    assign last_of_run  = head.last;

    `CLSL_ASSERT(a_queue_bound, status.count <= FIFO_CNT_BITS'(FIFO_DEPTH), "token queue overflow")
    `CLSL_ASSERT_IMPL(a_end_is_last, out_valid && token_kind == KIND_END, last_of_run, "end token not last of its byte")
    `CLSL_ASSERT_IMPL(a_eqeq_len, out_valid && token_kind == KIND_EQEQ, token_length == 32'd2, "'==' token length wrong")
    `CLSL_ASSERT_IMPL(a_push_room, push_count != 2'd0, status.count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2), "tokens pushed without room")

endmodule
